// ===== src/i2c_tag_fifo_framer_macros.svh =====
// Assertion helpers for the checker file.
`ifndef I2C_TAG_FIFO_FRAMER_MACROS_SVH
`define I2C_TAG_FIFO_FRAMER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define TFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/i2c_tfr_pkg.sv =====
`default_nettype none

package i2c_tfr_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    FUNC_HEADER  = 2'd0,
    FUNC_WR_BYTE = 2'd1,
    FUNC_RX_WORD = 2'd2,
    FUNC_RSVD    = 2'd3
  } func_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_TX_WORD    = 2'd0,
    KIND_RX_BYTE    = 2'd1,
    KIND_LEN_ERR    = 2'd2,
    KIND_UNEXPECTED = 2'd3
  } kind_e;

  // Message mode
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  localparam int unsigned CFG_W     = 14;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TX_FIFO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_FIFO = 1'd1;

  localparam logic [CFG_W-1:0] FIFO_BYTES_RST = 14'd64;
  localparam logic [CFG_W-1:0] TX_OVERHEAD    = 14'd4;
  localparam logic [CFG_W-1:0] RX_OVERHEAD    = 14'd2;

  // Tag bytes
  localparam logic [7:0] TAG_START   = 8'h81;
  localparam logic [7:0] TAG_WR      = 8'h82;
  localparam logic [7:0] TAG_WR_STOP = 8'h83;
  localparam logic [7:0] TAG_RD      = 8'h85;
  localparam logic [7:0] TAG_RD_STOP = 8'h87;

  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  dev_addr;
    logic        is_read;
    logic        is_last_msg;
    logic [7:0]  length;
    logic [7:0]  data_byte;
    logic [31:0] rx_word;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] fifo_word;
    logic [7:0]  rx_byte;
    logic        last_of_run;
    logic        message_done;
  } out_t;

  // Results caused by one input item, handed from the core to the output buffer
  typedef struct packed {
    logic            vld;
    kind_e           kind;
    logic [31:0]     word;
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            done;
  } run_t;

endpackage

`default_nettype wire

// ===== src/i2c_tfr_core.sv =====
`default_nettype none

module i2c_tfr_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_vld_i,
  output logic                                  in_stall_o,
  input  wire i2c_tfr_pkg::in_t                 in_data_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [i2c_tfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [i2c_tfr_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                             run_ready_i,
  output i2c_tfr_pkg::run_t                     run_o
);

  // Input register
  logic              in_vld_q;
  i2c_tfr_pkg::in_t  in_q;
  logic              step;

  // Config registers
  logic [i2c_tfr_pkg::CFG_W-1:0] tx_fifo_q, rx_fifo_q;

  // Message state
  i2c_tfr_pkg::mode_e mode_q, mode_d;
  logic [7:0]         bytes_left_q, bytes_left_d;
  logic [1:0]         lane_q, lane_d;
  logic [23:0]        pack_q, pack_d;
  logic               first_q, first_d;

  // Working values
  logic [i2c_tfr_pkg::CFG_W-1:0] lim;
  logic [7:0]  addr8, tag, bl_dec;
  logic [31:0] wr_word, rx_shift;
  logic [2:0]  rx_avail, rx_cnt;
  logic [7:0]  bl_after_rx;
  i2c_tfr_pkg::run_t run;

  assign step       = in_vld_q & run_ready_i;
  assign in_stall_o = in_vld_q & ~run_ready_i;

  // Input register: loads whenever the slot is free or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_fifo_q <= i2c_tfr_pkg::FIFO_BYTES_RST;
      rx_fifo_q <= i2c_tfr_pkg::FIFO_BYTES_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == i2c_tfr_pkg::CFG_TX_FIFO) begin
        tx_fifo_q <= cfg_data_i;
      end
      if (cfg_idx_i == i2c_tfr_pkg::CFG_RX_FIFO) begin
        rx_fifo_q <= cfg_data_i;
      end
    end
  end

  // Shared datapath pieces
  always_comb begin
    addr8 = {in_q.dev_addr, in_q.is_read};
    if (in_q.is_read) begin
      lim = (rx_fifo_q > i2c_tfr_pkg::RX_OVERHEAD) ? rx_fifo_q - i2c_tfr_pkg::RX_OVERHEAD : '0;
      tag = in_q.is_last_msg ? i2c_tfr_pkg::TAG_RD_STOP : i2c_tfr_pkg::TAG_RD;
    end else begin
      lim = (tx_fifo_q > i2c_tfr_pkg::TX_OVERHEAD) ? tx_fifo_q - i2c_tfr_pkg::TX_OVERHEAD : '0;
      tag = in_q.is_last_msg ? i2c_tfr_pkg::TAG_WR_STOP : i2c_tfr_pkg::TAG_WR;
    end
    // little-endian byte packing
    wr_word  = {8'b0, pack_q} | ({24'b0, in_q.data_byte} << {lane_q, 3'b000});
    bl_dec   = bytes_left_q - 8'd1;
    // first read word carries two tag bytes in its low lanes
    rx_shift = first_q ? {16'b0, in_q.rx_word[31:16]} : in_q.rx_word;
    rx_avail = first_q ? 3'd2 : 3'd4;
    rx_cnt   = (bytes_left_q < {5'b0, rx_avail}) ? bytes_left_q[2:0] : rx_avail;
    bl_after_rx = bytes_left_q - {5'b0, rx_cnt};
  end

  // Item decode and next state
  always_comb begin
    mode_d       = mode_q;
    bytes_left_d = bytes_left_q;
    lane_d       = lane_q;
    pack_d       = pack_q;
    first_d      = first_q;
    run          = '0;
    run.kind     = i2c_tfr_pkg::KIND_UNEXPECTED;
    run.cnt      = 3'd1;

    if (in_q.func == i2c_tfr_pkg::FUNC_HEADER) begin
      if ({6'b0, in_q.length} > lim) begin
        mode_d       = i2c_tfr_pkg::MODE_IDLE;
        bytes_left_d = '0;
        run.kind     = i2c_tfr_pkg::KIND_LEN_ERR;
      end else begin
        bytes_left_d = in_q.length;
        lane_d       = '0;
        pack_d       = '0;
        first_d      = 1'b1;
        if (in_q.length == 8'd0) begin
          mode_d = i2c_tfr_pkg::MODE_IDLE;
        end else if (in_q.is_read) begin
          mode_d = i2c_tfr_pkg::MODE_READ;
        end else begin
          mode_d = i2c_tfr_pkg::MODE_WRITE;
        end
        run.kind = i2c_tfr_pkg::KIND_TX_WORD;
        run.word = {in_q.length, tag, addr8, i2c_tfr_pkg::TAG_START};
        run.done = (in_q.length == 8'd0);
      end
    end else if (in_q.func == i2c_tfr_pkg::FUNC_WR_BYTE &&
                 mode_q == i2c_tfr_pkg::MODE_WRITE && bytes_left_q != 8'd0) begin
      bytes_left_d = bl_dec;
      if (lane_q == 2'd3 || bl_dec == 8'd0) begin
        pack_d   = '0;
        lane_d   = '0;
        if (bl_dec == 8'd0) begin
          mode_d = i2c_tfr_pkg::MODE_IDLE;
        end
        run.kind = i2c_tfr_pkg::KIND_TX_WORD;
        run.word = wr_word;
        run.done = (bl_dec == 8'd0);
      end else begin
        pack_d  = wr_word[23:0];
        lane_d  = lane_q + 2'd1;
        run.cnt = 3'd0;
      end
    end else if (in_q.func == i2c_tfr_pkg::FUNC_RX_WORD &&
                 mode_q == i2c_tfr_pkg::MODE_READ && bytes_left_q != 8'd0) begin
      bytes_left_d = bl_after_rx;
      first_d      = 1'b0;
      if (bl_after_rx == 8'd0) begin
        mode_d = i2c_tfr_pkg::MODE_IDLE;
      end
      run.kind  = i2c_tfr_pkg::KIND_RX_BYTE;
      run.bytes = rx_shift;
      run.cnt   = rx_cnt;
      run.done  = (bl_after_rx == 8'd0);
    end
    run.vld = in_vld_q && (run.cnt != 3'd0);
  end

  assign run_o = run;

  // Message state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= i2c_tfr_pkg::MODE_IDLE;
      bytes_left_q <= '0;
      lane_q       <= '0;
      pack_q       <= '0;
      first_q      <= 1'b1;
    end else if (step) begin
      mode_q       <= mode_d;
      bytes_left_q <= bytes_left_d;
      lane_q       <= lane_d;
      pack_q       <= pack_d;
      first_q      <= first_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/i2c_tfr_outbuf.sv =====
`default_nettype none

module i2c_tfr_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire i2c_tfr_pkg::run_t run_i,
  output logic                   run_ready_o,
  output logic                   out_vld_o,
  input  wire logic              out_stall_i,
  output i2c_tfr_pkg::out_t      out_data_o
);

  logic              busy_q;
  logic [1:0]        idx_q;
  i2c_tfr_pkg::run_t run_q;
  logic              take, is_last, finish;

  assign is_last     = ({1'b0, idx_q} == run_q.cnt - 3'd1);
  assign take        = busy_q & ~out_stall_i;
  assign finish      = take & is_last;
  assign run_ready_o = ~busy_q | finish;

  // Control: load a new run or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (run_ready_o && run_i.vld) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (finish) begin
      busy_q <= 1'b0;
    end else if (take) begin
      idx_q  <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_ready_o && run_i.vld) begin
      run_q <= run_i;
    end
  end

  // One result per transaction
  assign out_vld_o               = busy_q;
  assign out_data_o.result_kind  = run_q.kind;
  assign out_data_o.fifo_word    = run_q.word;
  assign out_data_o.rx_byte      = run_q.bytes[idx_q];
  assign out_data_o.last_of_run  = is_last;
  assign out_data_o.message_done = is_last & run_q.done;

endmodule

`default_nettype wire

// ===== src/i2c_tag_fifo_framer.sv =====
// Channel  Handshake            Payload
// -------  -------------------  -----------------------------------
// in       in_vld_i/in_stall_o  in_data_i  (i2c_tfr_pkg::in_t)
// out      out_vld_o/out_stall_i out_data_o (i2c_tfr_pkg::out_t)
// cfg      cfg_we_i             cfg_idx_i, cfg_data_i (14 bits)
//
// An item is registered on acceptance and decoded into the output buffer's
// result register once that is free; a stall there holds the item.
// Headers, unexpected items and full or final write words give one result; a
// receive word with N due bytes gives N results via the byte-wide serializer (N <= 4).
// Reset clears the message state and sets both FIFO sizes to 64 bytes.
// Output stall holds the current result and backs up into in_stall_o.
`default_nettype none

module i2c_tag_fifo_framer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_vld_i,
  output logic                                   in_stall_o,
  input  wire i2c_tfr_pkg::in_t                  in_data_i,
  output logic                                   out_vld_o,
  input  wire logic                              out_stall_i,
  output i2c_tfr_pkg::out_t                      out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [i2c_tfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [i2c_tfr_pkg::CFG_W-1:0]     cfg_data_i
);

  i2c_tfr_pkg::run_t run;
  logic              run_ready;

  i2c_tfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (in_vld_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .run_ready_i (run_ready),
    .run_o       (run)
  );

  i2c_tfr_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_i       (run),
    .run_ready_o (run_ready),
    .out_vld_o   (out_vld_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== src/i2c_tfr_checker.sv =====
`default_nettype none
`include "i2c_tag_fifo_framer_macros.svh"

module i2c_tfr_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_vld_o,
  input wire logic              out_stall_i,
  input wire i2c_tfr_pkg::out_t out_data_o
);

  // A stalled result stays offered
  `TFR_ASSERT(a_out_hold, out_vld_o && out_stall_i |=> out_vld_o, "out valid dropped under stall")

  // No result is offered once reset has been sampled
  `TFR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_vld_o, "out valid after reset")

  // Only received-byte runs span more than one result
  `TFR_ASSERT(a_single_run,
    out_vld_o && out_data_o.result_kind != i2c_tfr_pkg::KIND_RX_BYTE |-> out_data_o.last_of_run,
    "multi-result run of non-byte kind")

  // A run continues with the next byte right after a non-final transaction
  `TFR_ASSERT(a_run_cont,
    out_vld_o && !out_stall_i && !out_data_o.last_of_run |=>
      out_vld_o && out_data_o.result_kind == i2c_tfr_pkg::KIND_RX_BYTE,
    "byte run broken")

  // Message completion only on the final result of a run
  `TFR_ASSERT(a_done_last,
    out_vld_o && out_data_o.message_done |-> out_data_o.last_of_run,
    "message_done without last_of_run")

endmodule

bind i2c_tag_fifo_framer i2c_tfr_checker u_chk (.*);

`default_nettype wire
